[src/cpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cpa_pkg;
   localparam int MAX_CONTAINERS = 16;
   localparam int BUFFER_BYTES   = 4096;
   localparam int HEADER_BYTES   = 16;
   localparam int ID_W  = $clog2(MAX_CONTAINERS);
   localparam int OFF_W = 12;
   localparam int BYT_W = 13;

   localparam logic [1:0] ST_CREATED = 2'd0;
   localparam logic [1:0] ST_FREED   = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;

   localparam logic ACT_CREATE = 1'b0;
   localparam logic ACT_FREE   = 1'b1;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [BYT_W-1:0] bytes;
   } entry_type;
endpackage
`default_nettype wire

[src/container_pool_allocator.sv]
// Path, acceptance to response: a free of an unmapped id goes straight to the response, a free of
// the top region reads its entry first, and a top allocation first scans the id table; a merge walk
// adds repeated searches of the id table.
// Throughput: one request at a time, the next accepted the cycle after the response leaves;
// the id table memory (one read port) paces every scan and merge search.
// Reset: flags and top pointer clear; the offset/size table stays undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module container_pool_allocator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_action,
   input  wire logic [15:0]               req_elem_count,
   input  wire logic [15:0]               req_elem_size,
   input  wire logic [3:0]                req_container_id,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [3:0]                     rsp_result_id,
   output logic [11:0]                    rsp_region_offset
);
   import cpa_pkg::*;

   localparam int NC = MAX_CONTAINERS;
   localparam int CW = ID_W + 1;
   localparam logic [BYT_W:0] LIMIT = (BYT_W+1)'(BUFFER_BYTES - HEADER_BYTES);
   localparam logic [BYT_W:0] HDR   = (BYT_W+1)'(HEADER_BYTES);
   localparam logic [BYT_W:0] BUF   = (BYT_W+1)'(BUFFER_BYTES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;  // issue read of entry scan_ff
   localparam logic [3:0] S_SCHK  = 4'd3;  // check data of scanned entry
   localparam logic [3:0] S_SPLIT = 4'd4;  // write split tail, set head for merge
   localparam logic [3:0] S_MSRCH = 4'd5;  // issue read for merge search
   localparam logic [3:0] S_MCHK  = 4'd6;
   localparam logic [3:0] S_MWB   = 4'd7;  // write back merged head size
   localparam logic [3:0] S_FRD   = 4'd8;
   localparam logic [3:0] S_FCHK  = 4'd9;
   localparam logic [3:0] S_TOP   = 4'd10;
   localparam logic [3:0] S_TAKE  = 4'd11; // write reused entry
   localparam logic [3:0] S_RSP   = 4'd12;

   // id table memory
   entry_type mem [NC];
   entry_type rd_ff;
   logic [ID_W-1:0] ra;
   logic            we;
   logic [ID_W-1:0] wa;
   entry_type       wd;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   logic [NC-1:0] pres_ff, pres_in, free_ff, free_in;
   logic [BYT_W-1:0] top_ff, top_in;
   logic [3:0] st_ff, st_in;
   logic [15:0] cnt_ff, cnt_in, sz_ff, sz_in;
   logic [ID_W-1:0] cid_ff, cid_in;
   logic [BYT_W:0] need_ff, need_in;
   logic [CW-1:0] scan_ff, scan_in, k_ff, k_in;
   logic [ID_W-1:0] head_ff, head_in, reuse_ff, reuse_in;
   logic [BYT_W:0] hbytes_ff, hbytes_in, nxt_ff, nxt_in;
   logic [OFF_W-1:0] hoff_ff, hoff_in;
   logic       mret_ff, mret_in; // merge came from split: go to TAKE after
   logic [1:0] stat_ff, stat_in;
   logic [3:0] rid_ff, rid_in;
   logic [11:0] roff_ff, roff_in;
   logic [31:0] prod_ff, prod_in;

   // first spare id, priority encoder over presence flags
   logic [ID_W-1:0] spare;
   logic            spare_ok;
   always_comb begin
      spare = '0;
      spare_ok = 1'b0;
      for (int i = NC-1; i >= 0; i--) begin
         if (!pres_ff[i]) begin
            spare = ID_W'(i);
            spare_ok = 1'b1;
         end
      end
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_RSP);
   assign rsp_status = stat_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_region_offset = roff_ff;

   always_comb begin
      logic [BYT_W:0] ebytes, tail;
      logic [BYT_W:0] eend;
      st_in = st_ff; cnt_in = cnt_ff; sz_in = sz_ff; cid_in = cid_ff;
      need_in = need_ff; scan_in = scan_ff; k_in = k_ff; head_in = head_ff;
      reuse_in = reuse_ff; hbytes_in = hbytes_ff; nxt_in = nxt_ff; hoff_in = hoff_ff;
      mret_in = mret_ff; stat_in = stat_ff; rid_in = rid_ff; roff_in = roff_ff;
      pres_in = pres_ff; free_in = free_ff; top_in = top_ff; prod_in = prod_ff;
      ra = scan_ff[ID_W-1:0]; we = 1'b0; wa = '0; wd = '0;
      ebytes = {1'b0, rd_ff.bytes};
      tail = ebytes - HDR - need_ff;
      eend = (BYT_W+1)'(rd_ff.offset) + HDR + ebytes;
      unique case (st_ff)
         S_IDLE: if (req_valid) begin
            cnt_in = req_elem_count; sz_in = req_elem_size;
            cid_in = req_container_id;
            stat_in = ST_REJECT; rid_in = '0; roff_in = '0;
            if (req_action == ACT_FREE) begin
               if (pres_ff[req_container_id]) st_in = S_FRD;
               else st_in = S_RSP;
            end else st_in = S_MUL;
         end
         S_MUL: begin
            prod_in = cnt_ff * sz_ff;
            scan_in = '0;
            if (cnt_ff == 16'd0 || sz_ff == 16'd0) st_in = S_RSP;
            else st_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_ff == CW'(NC)) st_in = S_TOP;
            else if (scan_ff == '0 && prod_ff > 32'(LIMIT)) st_in = S_RSP;
            else begin
               need_in = prod_ff[BYT_W:0];
               if (pres_ff[scan_ff[ID_W-1:0]] && free_ff[scan_ff[ID_W-1:0]]) begin
                  ra = scan_ff[ID_W-1:0];
                  st_in = S_SCHK;
               end else scan_in = scan_ff + 1'b1;
            end
         end
         S_SCHK: begin
            reuse_in = scan_ff[ID_W-1:0];
            if (ebytes == need_ff) begin
               hoff_in = rd_ff.offset;
               st_in = S_TAKE;
            end else if (ebytes >= need_ff + HDR + 1'b1 && spare_ok) begin
               hoff_in = rd_ff.offset;
               head_in = spare;
               hbytes_in = tail;
               nxt_in = eend; // end of tail equals end of old region
               st_in = S_SPLIT;
            end else begin
               scan_in = scan_ff + 1'b1;
               st_in = S_SCAN;
            end
         end
         S_SPLIT: begin
            we = 1'b1; wa = head_ff;
            wd.offset = OFF_W'((BYT_W+1)'(hoff_ff) + HDR + need_ff);
            wd.bytes = hbytes_ff[BYT_W-1:0];
            hoff_in = wd.offset; // tail becomes the merge head
            pres_in[head_ff] = 1'b1; free_in[head_ff] = 1'b1;
            mret_in = 1'b1; k_in = '0;
            st_in = S_MSRCH;
         end
         S_MSRCH: begin
            if (nxt_ff >= {1'b0, top_ff} || k_ff == CW'(NC)) st_in = S_MWB;
            else if (pres_ff[k_ff[ID_W-1:0]] && free_ff[k_ff[ID_W-1:0]]) begin
               ra = k_ff[ID_W-1:0];
               st_in = S_MCHK;
            end else k_in = k_ff + 1'b1;
         end
         S_MCHK: begin
            // only present free entries are checked; if none sits at nxt, the walk stops
            if ((BYT_W+1)'(rd_ff.offset) == nxt_ff) begin
               hbytes_in = hbytes_ff + ebytes + HDR;
               nxt_in = nxt_ff + HDR + ebytes;
               if (k_ff[ID_W-1:0] != head_ff) pres_in[k_ff[ID_W-1:0]] = 1'b0;
               k_in = '0;
            end else k_in = k_ff + 1'b1;
            st_in = S_MSRCH;
         end
         S_MWB: begin
            we = 1'b1; wa = head_ff;
            wd.offset = hoff_ff; wd.bytes = hbytes_ff[BYT_W-1:0];
            if (mret_ff) begin
               // read the reused entry back for its offset
               ra = reuse_ff;
               st_in = S_TAKE;
            end else begin
               stat_in = ST_FREED;
               st_in = S_RSP;
            end
         end
         S_FRD: begin
            ra = cid_ff; st_in = S_FCHK;
         end
         S_FCHK: begin
            if (eend == {1'b0, top_ff}) begin
               top_in = BYT_W'(rd_ff.offset);
               pres_in[cid_ff] = 1'b0; free_in[cid_ff] = 1'b0;
               stat_in = ST_FREED;
               st_in = S_RSP;
            end else begin
               free_in[cid_ff] = 1'b1;
               head_in = cid_ff; hoff_in = rd_ff.offset; hbytes_in = ebytes;
               nxt_in = eend; mret_in = 1'b0; k_in = '0;
               st_in = S_MSRCH;
            end
         end
         S_TOP: begin
            if (BUF - {1'b0, top_ff} >= HDR + need_ff && spare_ok) begin
               we = 1'b1; wa = spare;
               wd.offset = top_ff[OFF_W-1:0]; wd.bytes = need_ff[BYT_W-1:0];
               pres_in[spare] = 1'b1; free_in[spare] = 1'b0;
               top_in = BYT_W'({1'b0, top_ff} + HDR + need_ff);
               stat_in = ST_CREATED; rid_in = 4'(spare); roff_in = top_ff[11:0];
            end
            st_in = S_RSP;
         end
         S_TAKE: begin
            // rd_ff holds the reused entry, read in SCHK or MWB
            we = 1'b1; wa = reuse_ff;
            wd.offset = rd_ff.offset;
            wd.bytes = need_ff[BYT_W-1:0];
            free_in[reuse_ff] = 1'b0;
            stat_in = ST_CREATED; rid_in = 4'(reuse_ff);
            roff_in = rd_ff.offset;
            st_in = S_RSP;
         end
         S_RSP: if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; pres_ff <= '0; free_ff <= '0; top_ff <= '0;
      end else begin
         st_ff <= st_in; pres_ff <= pres_in; free_ff <= free_in; top_ff <= top_in;
      end
      cnt_ff <= cnt_in; sz_ff <= sz_in; cid_ff <= cid_in;
      need_ff <= need_in; scan_ff <= scan_in; k_ff <= k_in; head_ff <= head_in;
      reuse_ff <= reuse_in; hbytes_ff <= hbytes_in; nxt_ff <= nxt_in;
      hoff_ff <= hoff_in; mret_ff <= mret_in; stat_ff <= stat_in; rid_ff <= rid_in;
      roff_ff <= roff_in; prod_ff <= prod_in;
   end

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response phases overlap");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, top_ff} <= BUF)
      else $error("top past buffer end");
endmodule
`default_nettype wire

[verif/container_pool_allocator_tb.sv]
`timescale 1ns / 1ps
module container_pool_allocator_tb;
   import cpa_pkg::*;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Request channel.
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACT_CREATE;
   logic [15:0] req_elem_count = '0;
   logic [15:0] req_elem_size = '0;
   logic [3:0]  req_container_id = '0;

   // Response channel.
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_result_id;
   logic [11:0] rsp_region_offset;

   container_pool_allocator i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_action, .req_elem_count, .req_elem_size,
      .req_container_id,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_result_id, .rsp_region_offset
   );

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  id;
      logic [11:0] offset;
   } alloc_result_type;

   // Shadow copy of the pool: id table and top pointer.
   logic [12:0] pool_offset [MAX_CONTAINERS];
   logic [12:0] pool_bytes  [MAX_CONTAINERS];
   logic        pool_mapped [MAX_CONTAINERS];
   logic        pool_free   [MAX_CONTAINERS];
   logic [13:0] pool_top;

   alloc_result_type pending_results[$];
   int  error_count = 0;
   logic hold_rsp = 1'b0;  // long receiver hold-off, set by the stimulus

   function automatic int pool_id_at(logic [12:0] off);
      for (int k = 0; k < MAX_CONTAINERS; k++)
         if (pool_mapped[k] && pool_offset[k] == off) return k;
      return -1;
   endfunction

   function automatic int pool_spare_id();
      for (int k = 0; k < MAX_CONTAINERS; k++)
         if (!pool_mapped[k]) return k;
      return -1;
   endfunction

   // Absorb the free regions that follow head; drop their ids.
   function automatic void pool_coalesce(int head);
      int j;
      logic [13:0] nxt;
      logic [12:0] jb;
      nxt = 14'(pool_offset[head] + HEADER_BYTES + pool_bytes[head]);
      while (nxt < pool_top) begin
         j = pool_id_at(nxt[12:0]);
         if (j < 0 || !pool_free[j]) break;
         jb = pool_bytes[j];
         pool_bytes[head] = 13'(pool_bytes[head] + jb + HEADER_BYTES);
         for (int k = 0; k < MAX_CONTAINERS; k++)
            if (k != head && pool_mapped[k] && pool_offset[k] == nxt) pool_mapped[k] = 1'b0;
         nxt = 14'(nxt + HEADER_BYTES + jb);
      end
   endfunction

   // First fit in id order: exact size, or split with a spare id for the tail.
   function automatic int pool_reuse(logic [12:0] need);
      int s;
      for (int i = 0; i < MAX_CONTAINERS; i++) begin
         if (!pool_mapped[i] || !pool_free[i]) continue;
         if (pool_bytes[i] == need) return i;
         if (pool_bytes[i] >= need + HEADER_BYTES + 1) begin
            s = pool_spare_id();
            if (s >= 0) begin
               pool_offset[s] = 13'(pool_offset[i] + HEADER_BYTES + need);
               pool_bytes[s]  = 13'(pool_bytes[i] - HEADER_BYTES - need);
               pool_mapped[s] = 1'b1;
               pool_free[s]   = 1'b1;
               pool_coalesce(s);
               return i;
            end
         end
      end
      return -1;
   endfunction

   function automatic alloc_result_type pool_apply(logic act, logic [15:0] cnt,
                                                   logic [15:0] sz, logic [3:0] cid);
      alloc_result_type r;
      logic [31:0] prod;
      int id;
      r = '{status: ST_REJECT, id: '0, offset: '0};
      prod = cnt * sz;
      if (act == ACT_CREATE) begin
         if (cnt != 0 && sz != 0 && prod <= BUFFER_BYTES - HEADER_BYTES) begin
            id = pool_reuse(prod[12:0]);
            if (id >= 0) begin
               pool_bytes[id] = prod[12:0];
               pool_free[id]  = 1'b0;
               r = '{status: ST_CREATED, id: id[3:0], offset: pool_offset[id][11:0]};
            end else if (BUFFER_BYTES - pool_top >= HEADER_BYTES + prod) begin
               id = pool_spare_id();
               if (id >= 0) begin
                  pool_offset[id] = pool_top[12:0];
                  pool_bytes[id]  = prod[12:0];
                  pool_mapped[id] = 1'b1;
                  pool_free[id]   = 1'b0;
                  pool_top = 14'(pool_top + HEADER_BYTES + prod);
                  r = '{status: ST_CREATED, id: id[3:0], offset: pool_offset[id][11:0]};
               end
            end
         end
      end else if (pool_mapped[cid]) begin
         if (pool_offset[cid] + HEADER_BYTES + pool_bytes[cid] == pool_top) begin
            pool_top = {1'b0, pool_offset[cid]};
            pool_mapped[cid] = 1'b0;
            pool_free[cid]   = 1'b0;
         end else begin
            pool_free[cid] = 1'b1;
            pool_coalesce(cid);
         end
         r.status = ST_FREED;
      end
      return r;
   endfunction

   // Hold the request until accepted; predict at acceptance.
   task automatic send_request(logic act, logic [15:0] cnt, logic [15:0] sz,
                               logic [3:0] cid);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_elem_count   <= cnt;
      req_elem_size    <= sz;
      req_container_id <= cid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(pool_apply(act, cnt, sz, cid));
   endtask

   // Random gap after a request: mostly none or short, rarely long.
   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 99);
      n = (n < 55) ? 0 : (n < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Frees (none in stress); creates mostly small, some exact reuse, a few huge or empty.
   task automatic random_request(logic stress);
      int pick;
      logic [15:0] cnt, sz;
      logic [3:0] cid;
      pick = $urandom_range(0, 99);
      cid  = 4'($urandom_range(0, 15));
      if (pick < 40 && !stress) begin
         send_request(ACT_FREE, 16'($urandom), 16'($urandom), cid);
      end else begin
         if (pick < 85) begin
            cnt = 16'($urandom_range(1, 8));
            sz  = 16'($urandom_range(1, 40));
         end else if (pick < 92) begin
            cnt = 16'd1;
            sz  = 16'(pool_bytes[cid]);
         end else if (pick < 96) begin
            cnt = 16'($urandom);
            sz  = 16'($urandom);
         end else begin
            cnt = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
            sz  = (cnt == 16'd0) ? 16'($urandom) : 16'd0;
         end
         send_request(ACT_CREATE, cnt, sz, cid);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(0, 99);
         n = (n < 60) ? 0 : (n < 94) ? $urandom_range(1, 3) : $urandom_range(10, 50);
         if (hold_rsp) n = 400;
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response status=%0d id=%0d offset=%0d", $time,
                     rsp_status, rsp_result_id, rsp_region_offset);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_result_id !== exp_r.id) begin
               $display("%0t: result_id expected %0d actual %0d", $time, exp_r.id,
                        rsp_result_id);
               error_count++;
            end
            if (rsp_region_offset !== exp_r.offset) begin
               $display("%0t: region_offset expected %0d actual %0d", $time,
                        exp_r.offset, rsp_region_offset);
               error_count++;
            end
         end
      end
   end

   // Directed rows: action, count, size, id, and a typed-in result where obvious.
   typedef struct {
      logic        act;
      logic [15:0] cnt;
      logic [15:0] sz;
      logic [3:0]  cid;
      logic        known;
      logic [1:0]  status;
      logic [3:0]  id;
      logic [11:0] offset;
   } stim_row_type;

   localparam int N_ROWS = 20;
   stim_row_type stim_table [N_ROWS] = '{
      '{ACT_FREE,   16'd0,     16'd0,     4'd0,  1'b1, ST_REJECT,  4'd0, 12'd0},   // unmapped
      '{ACT_FREE,   16'hFFFF,  16'hFFFF,  4'd15, 1'b1, ST_REJECT,  4'd0, 12'd0},
      '{ACT_CREATE, 16'd0,     16'd5,     4'd0,  1'b1, ST_REJECT,  4'd0, 12'd0},   // empty
      '{ACT_CREATE, 16'd5,     16'd0,     4'd0,  1'b1, ST_REJECT,  4'd0, 12'd0},
      '{ACT_CREATE, 16'hFFFF,  16'hFFFF,  4'd0,  1'b1, ST_REJECT,  4'd0, 12'd0},   // oversized
      '{ACT_CREATE, 16'd1,     16'd4081,  4'd0,  1'b1, ST_REJECT,  4'd0, 12'd0},
      '{ACT_CREATE, 16'd1,     16'd100,   4'd0,  1'b1, ST_CREATED, 4'd0, 12'd0},
      '{ACT_CREATE, 16'd10,    16'd10,    4'd0,  1'b1, ST_CREATED, 4'd1, 12'd116},
      '{ACT_CREATE, 16'd2,     16'd32,    4'd0,  1'b0, '0, '0, '0},
      '{ACT_CREATE, 16'd4,     16'd8,     4'd0,  1'b0, '0, '0, '0},
      '{ACT_FREE,   16'd0,     16'd0,     4'd3,  1'b0, '0, '0, '0},  // top pull-back
      '{ACT_FREE,   16'd0,     16'd0,     4'd1,  1'b0, '0, '0, '0},  // mark free
      '{ACT_FREE,   16'd0,     16'd0,     4'd0,  1'b0, '0, '0, '0},  // merge forward
      '{ACT_FREE,   16'd0,     16'd0,     4'd0,  1'b0, '0, '0, '0},  // free a free region
      '{ACT_CREATE, 16'd1,     16'd20,    4'd0,  1'b0, '0, '0, '0},  // split
      '{ACT_CREATE, 16'd1,     16'd180,   4'd0,  1'b0, '0, '0, '0},  // exact reuse
      '{ACT_CREATE, 16'd1,     16'd3000,  4'd0,  1'b0, '0, '0, '0},
      '{ACT_CREATE, 16'd1,     16'd4080,  4'd0,  1'b0, '0, '0, '0},  // no room
      '{ACT_FREE,   16'd0,     16'd0,     4'd4,  1'b0, '0, '0, '0},
      '{ACT_CREATE, 16'hAAAA,  16'h5555,  4'd0,  1'b1, ST_REJECT,  4'd0, 12'd0}
   };

   // Stimulus.
   initial begin
      alloc_result_type pred;
      for (int k = 0; k < MAX_CONTAINERS; k++) begin
         pool_offset[k] = '0;
         pool_bytes[k]  = '0;
         pool_mapped[k] = 1'b0;
         pool_free[k]   = 1'b0;
      end
      pool_top = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed-in rows must agree with the predictor too.
      foreach (stim_table[r]) begin
         send_request(stim_table[r].act, stim_table[r].cnt, stim_table[r].sz,
                      stim_table[r].cid);
         pred = pending_results[$];
         if (stim_table[r].known && (pred.status !== stim_table[r].status ||
             pred.id !== stim_table[r].id || pred.offset !== stim_table[r].offset)) begin
            $display("%0t: row %0d expected %0d/%0d/%0d actual %0d/%0d/%0d", $time, r,
                     stim_table[r].status, stim_table[r].id, stim_table[r].offset,
                     pred.status, pred.id, pred.offset);
            error_count++;
         end
         sender_gap();
      end
      drain_results();

      // Random traffic; partway, hold the receiver off so the block backs up.
      for (int n = 0; n < 430; n++) begin
         if (n == 150) hold_rsp = 1'b1;
         if (n == 154) hold_rsp = 1'b0;
         if (n == 300) drain_results();
         random_request(n >= 340 && n < 370);
         sender_gap();
      end
      drain_results();
      repeat (600) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #10000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
